@@ rtl/assert_macros.svh @@
// Assertion macros for the port-level checker of the handle table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define THT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define THT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/tht_pkg.sv @@
// Package of the typed handle table: sizes, codes and the slot entry type.
`default_nettype none

package tht_pkg;

   // Table geometry
   localparam int TABLE_SIZE = 4096;
   localparam int IDX_W      = $clog2(TABLE_SIZE);
   localparam int CNT_W      = IDX_W + 1;
   localparam int TYPE_W     = 8;
   localparam int HANDLE_W   = 32;
   localparam int TYPE_LSB   = 24;

   // Special handles
   localparam logic [HANDLE_W-1:0] HANDLE_PROCESS = 32'hFFFF_FFFF;
   localparam logic [HANDLE_W-1:0] HANDLE_THREAD  = 32'hFFFF_FFFE;

   // Channel widths
   localparam int REQ_DATA_W = 64;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 48;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   typedef enum logic [1:0] {
      FN_ALLOC   = 2'd0,
      FN_RELEASE = 2'd1,
      FN_RESOLVE = 2'd2,
      FN_NOP     = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      ST_OK              = 4'd0,
      ST_NULL            = 4'd1,
      ST_PROCESS         = 4'd2,
      ST_THREAD          = 4'd3,
      ST_THREAD_WRONG    = 4'd4,
      ST_INDEX_ZERO      = 4'd5,
      ST_EMPTY           = 4'd6,
      ST_STORED_MISMATCH = 4'd7,
      ST_REQ_MISMATCH    = 4'd8,
      ST_FULL            = 4'd9,
      ST_BAD_RELEASE     = 4'd10
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ANY_TYPE    = 1'b0,
      CSR_THREAD_TYPE = 1'b1
   } csr_index_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_EXEC = 1'b1
   } fsm_type;

   typedef struct packed {
      logic              valid;
      logic [TYPE_W-1:0] obj_type;
   } slot_entry_type;

endpackage

`default_nettype wire

@@ rtl/typed_handle_table_unit.sv @@
// Top level of the typed handle table: request decode, slot and stack memories.
`default_nettype none

// Typed handle table. Each request is taken in the IDLE state together with the
// synchronous read of the slot memory and the free-index stack; the EXEC state
// does the checks, the write-back and loading the response register; the block
// then takes the next request. A response that is not taken holds the EXEC
// state until the response register frees. No clearing pass is needed after
// reset: a slot counts as valid only when its index is non-zero and below the
// bump index, so entries never allocated read as empty whatever the memory
// holds.
module typed_handle_table_unit (
   input  wire                                clock,
   input  wire                                reset,
   // request channel
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // tdata: obj_type[7:0], slot_index[19:8], handle_in[51:20],
   //        requested_type[59:52], zero padding[63:60]
   input  wire  [tht_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tuser: func[1:0]
   input  wire  [tht_pkg::REQ_USER_W-1:0]     req_tuser,
   // response channel
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // tdata: handle_out[31:0], resolved_index[43:32], status[47:44]
   output logic [tht_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // register write port
   input  wire                                csr_we,
   input  wire  [tht_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [tht_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import tht_pkg::*;

   // Control state
   fsm_type              state_ff, state_in;
   logic [CNT_W-1:0]     bump_ff, bump_in;
   logic [CNT_W-1:0]     free_count_ff, free_count_in;
   logic [TYPE_W-1:0]    any_type_ff, thread_type_ff;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Captured request
   func_type             func_ff;
   logic [TYPE_W-1:0]    obj_type_ff;
   logic [IDX_W-1:0]     slot_index_ff;
   logic [HANDLE_W-1:0]  handle_ff;
   logic [TYPE_W-1:0]    req_type_ff;

   // Response payload
   logic [HANDLE_W-1:0]  rsp_handle_ff, rsp_handle_in;
   logic [IDX_W-1:0]     rsp_index_ff, rsp_index_in;
   status_type           rsp_status_ff, rsp_status_in;

   // Memories
   slot_entry_type       slot_mem [TABLE_SIZE];
   logic [IDX_W-1:0]     stack_mem [TABLE_SIZE];
   slot_entry_type       slot_rd_ff;
   logic [IDX_W-1:0]     stack_rd_ff;

   // Handshake and decode
   logic                 req_xfer;
   logic                 commit;
   logic [IDX_W-1:0]     slot_rd_addr;
   logic [CNT_W-1:0]     free_count_dec;
   logic [IDX_W-1:0]     stack_rd_addr;
   func_type             req_func;

   // Write-back controls
   logic                 slot_we;
   logic [IDX_W-1:0]     slot_wr_addr;
   slot_entry_type       slot_wr_data;
   logic                 stack_we;

   // Lookup results
   logic [IDX_W-1:0]     look_idx;
   logic                 look_valid;
   logic [IDX_W-1:0]     alloc_idx;
   logic [TYPE_W-1:0]    handle_type;

   assign req_func       = func_type'(req_tuser);
   assign req_xfer       = req_tvalid && req_tready;
   assign free_count_dec = free_count_ff - CNT_W'(1);
   assign stack_rd_addr  = free_count_dec[IDX_W-1:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (req_tvalid) state_in = FSM_EXEC;
         end
         FSM_EXEC: begin
            if (!rsp_valid_ff || rsp_tready) state_in = FSM_IDLE;
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_tready   = 1'b0;
      commit       = 1'b0;
      slot_rd_addr = look_idx;
      case (state_ff)
         FSM_IDLE: begin
            req_tready = 1'b1;
            if (req_func == FN_RELEASE) begin
               slot_rd_addr = req_tdata[19:8];
            end else begin
               slot_rd_addr = req_tdata[20 +: IDX_W];
            end
         end
         FSM_EXEC: begin
            commit = !rsp_valid_ff || rsp_tready;
         end
         default: ;
      endcase
   end

   // Memory ports: one registered read each, written at commit
   always_ff @(posedge clock) begin
      slot_rd_ff <= slot_mem[slot_rd_addr];
      if (slot_we) slot_mem[slot_wr_addr] <= slot_wr_data;
   end

   always_ff @(posedge clock) begin
      stack_rd_ff <= stack_mem[stack_rd_addr];
      if (stack_we) stack_mem[free_count_ff[IDX_W-1:0]] <= slot_index_ff;
   end

   // Slot lookup for release and resolve
   always_comb begin
      if (func_ff == FN_RELEASE) begin
         look_idx = slot_index_ff;
      end else begin
         look_idx = handle_ff[IDX_W-1:0];
      end
      look_valid  = (look_idx != '0) && ({1'b0, look_idx} < bump_ff) && slot_rd_ff.valid;
      handle_type = handle_ff[TYPE_LSB +: TYPE_W];
   end

   // Operation: checks, write-back and result
   always_comb begin
      bump_in       = bump_ff;
      free_count_in = free_count_ff;
      alloc_idx     = bump_ff[IDX_W-1:0];
      slot_we       = 1'b0;
      slot_wr_addr  = look_idx;
      slot_wr_data  = slot_rd_ff;
      stack_we      = 1'b0;
      rsp_handle_in = '0;
      rsp_index_in  = '0;
      rsp_status_in = ST_OK;
      case (func_ff)
         FN_ALLOC: begin
            if (bump_ff < CNT_W'(TABLE_SIZE)) begin
               alloc_idx = bump_ff[IDX_W-1:0];
               bump_in   = bump_ff + CNT_W'(1);
            end else if (free_count_ff != '0) begin
               alloc_idx     = stack_rd_ff;
               free_count_in = free_count_dec;
            end else begin
               rsp_status_in = ST_FULL;
            end
            if (rsp_status_in == ST_OK) begin
               slot_we       = commit;
               slot_wr_addr  = alloc_idx;
               slot_wr_data  = '{valid: 1'b1, obj_type: obj_type_ff};
               rsp_handle_in = (HANDLE_W'(obj_type_ff) << TYPE_LSB) | HANDLE_W'(alloc_idx);
            end
         end
         FN_RELEASE: begin
            if (!look_valid || free_count_ff >= CNT_W'(TABLE_SIZE)) begin
               rsp_status_in = ST_BAD_RELEASE;
            end else begin
               slot_we            = commit;
               slot_wr_data.valid = 1'b0;
               stack_we           = commit;
               free_count_in      = free_count_ff + CNT_W'(1);
            end
         end
         FN_RESOLVE: begin
            if (handle_ff == '0) begin
               rsp_status_in = ST_NULL;
            end else if (handle_ff == HANDLE_PROCESS) begin
               rsp_status_in = ST_PROCESS;
            end else if (handle_ff == HANDLE_THREAD) begin
               rsp_status_in = (req_type_ff == thread_type_ff) ? ST_THREAD : ST_THREAD_WRONG;
            end else if (look_idx == '0) begin
               rsp_status_in = ST_INDEX_ZERO;
            end else if (!look_valid) begin
               rsp_status_in = ST_EMPTY;
            end else if (slot_rd_ff.obj_type != handle_type) begin
               rsp_status_in = ST_STORED_MISMATCH;
            end else if (req_type_ff != any_type_ff && req_type_ff != handle_type) begin
               rsp_status_in = ST_REQ_MISMATCH;
            end else begin
               rsp_index_in = look_idx;
            end
         end
         default: ;
      endcase
   end

   // Response register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= FSM_IDLE;
         bump_ff        <= CNT_W'(1);
         free_count_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
         any_type_ff    <= '0;
         thread_type_ff <= TYPE_W'(1);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            bump_ff       <= bump_in;
            free_count_ff <= free_count_in;
         end
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_ANY_TYPE:    any_type_ff    <= csr_wdata;
               CSR_THREAD_TYPE: thread_type_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         func_ff       <= req_func;
         obj_type_ff   <= req_tdata[7:0];
         slot_index_ff <= req_tdata[19:8];
         handle_ff     <= req_tdata[51:20];
         req_type_ff   <= req_tdata[59:52];
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_handle_ff <= rsp_handle_in;
         rsp_index_ff  <= rsp_index_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_status_ff, rsp_index_ff, rsp_handle_ff};

endmodule

`default_nettype wire

@@ rtl/tht_checker.sv @@
// Port-level checker of the typed handle table and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module tht_checker (
   input wire                            clock,
   input wire                            reset,
   input wire                            req_tvalid,
   input wire                            req_tready,
   input wire                            rsp_tvalid,
   input wire                            rsp_tready,
   input wire [tht_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import tht_pkg::*;

   logic req_xfer;
   logic rsp_fail;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_fail = rsp_tdata[47:44] != ST_OK;

   // A stalled response holds
   `THT_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "response changed while stalled")

   // Nothing is offered straight after reset
   `THT_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_tvalid, "response valid after reset")

   // One request at a time: no transfer in the cycle after one
   `THT_ASSERT(a_one_in_flight, clock, reset, req_xfer |=> !req_tready, "request taken while busy")

   // With the output free, the response follows via the EXEC state and the response register
   `THT_ASSERT(a_latency, clock, reset, req_xfer && !rsp_tvalid |-> ##2 rsp_tvalid, "response late")

   // A failed operation gives no handle and no index
   `THT_ASSERT(a_fail_zero, clock, reset, rsp_tvalid && rsp_fail |-> rsp_tdata[43:0] == 44'd0, "failure with payload")

endmodule

bind typed_handle_table_unit tht_checker u_tht_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

@@ test/tht_checker.sv @@
// Checker of the typed handle table: watches both channels, predicts and compares responses.
`timescale 1ns / 1ps

module tht_scoreboard (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   input  wire                              req_tready,
   input  wire  [tht_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire  [tht_pkg::REQ_USER_W-1:0]   req_tuser,
   input  wire                              rsp_tvalid,
   input  wire                              rsp_tready,
   input  wire  [tht_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  wire                              csr_we,
   input  wire  [tht_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire  [tht_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                               failures,
   output int                               outstanding
);
   import tht_pkg::*;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [IDX_W-1:0]    index;
      status_type          status;
   } answer_type;

   // Own copy of the table state and register settings
   logic [TYPE_W-1:0]  any_code;
   logic [TYPE_W-1:0]  thread_code;
   logic [CNT_W-1:0]   bump;
   logic [CNT_W-1:0]   free_cnt;
   logic [IDX_W-1:0]   free_stack [TABLE_SIZE];
   bit                 slot_used  [TABLE_SIZE];
   logic [TYPE_W-1:0]  slot_kind  [TABLE_SIZE];

   answer_type pending_answers [$];

   task automatic report_mismatch(input string what);
      // keep the log readable if the block is badly broken
      if (failures < 100)
         $display("%0t ns: mismatch: %s", $realtime, what);
      failures++;
   endtask

   // Works out the response to one request and updates the table copy
   function automatic answer_type predict_answer(input func_type fn,
                                                 input logic [TYPE_W-1:0] obj_kind,
                                                 input logic [IDX_W-1:0] rel_idx,
                                                 input logic [HANDLE_W-1:0] hdl,
                                                 input logic [TYPE_W-1:0] want);
      answer_type         ans;
      logic [IDX_W-1:0]   idx;
      logic [TYPE_W-1:0]  hdl_kind;
      ans = '{handle: '0, index: '0, status: ST_OK};
      idx = '0;
      hdl_kind = hdl[TYPE_LSB +: TYPE_W];
      case (fn)
         FN_ALLOC: begin
            // bump index first, then recycle from the free stack
            if (bump < TABLE_SIZE) begin
               idx  = bump[IDX_W-1:0];
               bump = bump + 1'b1;
            end else if (free_cnt != 0) begin
               free_cnt = free_cnt - 1'b1;
               idx      = free_stack[free_cnt[IDX_W-1:0]];
            end else begin
               ans.status = ST_FULL;
            end
            if (ans.status == ST_OK) begin
               slot_used[idx] = 1'b1;
               slot_kind[idx] = obj_kind;
               ans.handle = (HANDLE_W'(obj_kind) << TYPE_LSB) | HANDLE_W'(idx);
            end
         end
         FN_RELEASE: begin
            if (!slot_used[rel_idx] || free_cnt >= TABLE_SIZE) begin
               ans.status = ST_BAD_RELEASE;
            end else begin
               slot_used[rel_idx] = 1'b0;
               free_stack[free_cnt[IDX_W-1:0]] = rel_idx;
               free_cnt = free_cnt + 1'b1;
            end
         end
         FN_RESOLVE: begin
            idx = hdl[IDX_W-1:0];
            if (hdl == '0)
               ans.status = ST_NULL;
            else if (hdl == HANDLE_PROCESS)
               ans.status = ST_PROCESS;
            else if (hdl == HANDLE_THREAD)
               ans.status = (want == thread_code) ? ST_THREAD : ST_THREAD_WRONG;
            else if (idx == '0)
               ans.status = ST_INDEX_ZERO;
            else if (!slot_used[idx])
               ans.status = ST_EMPTY;
            else if (slot_kind[idx] != hdl_kind)
               ans.status = ST_STORED_MISMATCH;
            else if (want != any_code && want != hdl_kind)
               ans.status = ST_REQ_MISMATCH;
            else
               ans.index = idx;
         end
         default: ;
      endcase
      return ans;
   endfunction

   always @(posedge clock) begin
      answer_type           exp_ans;
      answer_type           new_ans;
      logic [HANDLE_W-1:0]  got_handle;
      logic [IDX_W-1:0]     got_index;
      logic [3:0]           got_status;
      if (reset) begin
         any_code    = '0;
         thread_code = 8'd1;
         bump        = CNT_W'(1);
         free_cnt    = '0;
         foreach (slot_used[i]) slot_used[i] = 1'b0;
         pending_answers.delete();
         failures    = 0;
         outstanding <= 0;
      end else begin
         // the user must write registers only while the block is idle; the block does not enforce it
         if (csr_we) begin
            case (csr_index)
               CSR_ANY_TYPE:    any_code    = csr_wdata;
               CSR_THREAD_TYPE: thread_code = csr_wdata;
               default: ;
            endcase
         end

         // response transfer: compare against the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            got_handle = rsp_tdata[31:0];
            got_index  = rsp_tdata[43:32];
            got_status = rsp_tdata[47:44];
            if (pending_answers.size() == 0) begin
               report_mismatch($sformatf("response %h with no request outstanding", rsp_tdata));
            end else begin
               exp_ans = pending_answers.pop_front();
               if (got_status !== exp_ans.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            got_status, exp_ans.status));
               if (got_handle !== exp_ans.handle)
                  report_mismatch($sformatf("handle_out %h, expected %h",
                                            got_handle, exp_ans.handle));
               if (got_index !== exp_ans.index)
                  report_mismatch($sformatf("resolved_index %0d, expected %0d",
                                            got_index, exp_ans.index));
            end
         end

         // request transfer: predict after the response so a same-edge pair stays ordered
         if (req_tvalid && req_tready) begin
            new_ans = predict_answer(func_type'(req_tuser),
                                     req_tdata[7:0], req_tdata[19:8],
                                     req_tdata[51:20], req_tdata[59:52]);
            pending_answers = {pending_answers, new_ans};
         end

         outstanding <= pending_answers.size();
      end
   end

endmodule

@@ test/tb.sv @@
// Testbench top of the typed handle table: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb;
   import tht_pkg::*;

   localparam int QUIET_LIMIT = 4000;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   // tdata: obj_type, slot_index, handle_in, requested_type, zero padding
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   // tuser: func
   logic [REQ_USER_W-1:0]   req_tuser = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   // tdata: handle_out, resolved_index, status
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   int                      failures;
   int                      outstanding;
   int                      quiet_cycles = 0;
   int                      req_gap_pct = 0;
   int                      rsp_stall_pct = 0;
   logic [TYPE_W-1:0]       any_code_now = '0;
   logic [TYPE_W-1:0]       thread_code_now = 8'd1;
   logic [HANDLE_W-1:0]     live_handles [$];

   typed_handle_table_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   tht_scoreboard i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .failures    (failures),
      .outstanding (outstanding)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Receiver back-pressure
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);

   // Collect handles handed out, sampled mid-cycle ahead of the transfer edge
   always @(negedge clock)
      if (!reset && rsp_tvalid && rsp_tready && rsp_tdata[HANDLE_W-1:0] != '0)
         live_handles = {live_handles, rsp_tdata[HANDLE_W-1:0]};

   // Watchdog: too long without any transfer ends the run
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // One request transfer; valid stays high if the next one follows straight on
   task automatic send_req(input func_type fn, input logic [TYPE_W-1:0] obj_kind,
                           input logic [IDX_W-1:0] rel_idx, input logic [HANDLE_W-1:0] hdl,
                           input logic [TYPE_W-1:0] want);
      if ($urandom_range(99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_gap_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= fn;
      req_tdata  <= {4'b0, want, hdl, rel_idx, obj_kind};
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop sending and wait until every response is back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0 || rsp_tvalid);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_regs(input logic [TYPE_W-1:0] any_val,
                             input logic [TYPE_W-1:0] thread_val);
      csr_we    <= 1'b1;
      csr_index <= CSR_ANY_TYPE;
      csr_wdata <= any_val;
      @(posedge clock);
      csr_index <= CSR_THREAD_TYPE;
      csr_wdata <= thread_val;
      @(posedge clock);
      csr_we <= 1'b0;
      any_code_now    = any_val;
      thread_code_now = thread_val;
   endtask

   // Object types lean towards the register codes so matches are frequent
   function automatic logic [TYPE_W-1:0] pick_type();
      case ($urandom_range(3))
         0:       return any_code_now;
         1:       return thread_code_now;
         default: return TYPE_W'($urandom_range(255));
      endcase
   endfunction

   task automatic random_items(input int count);
      int unsigned          roll;
      int unsigned          pos;
      logic [HANDLE_W-1:0]  hdl;
      logic [TYPE_W-1:0]    want;
      repeat (count) begin
         roll = $urandom_range(99);
         if (roll < 30) begin
            send_req(FN_ALLOC, pick_type(), IDX_W'($urandom_range(4095)), $urandom,
                     TYPE_W'($urandom_range(255)));
         end else if (roll < 55) begin
            // mostly release a live handle, sometimes an arbitrary index
            if (live_handles.size() != 0 && $urandom_range(4) != 0) begin
               pos = $urandom_range(live_handles.size() - 1);
               hdl = live_handles[pos];
               live_handles.delete(pos);
            end else begin
               hdl = $urandom_range(4095);
            end
            send_req(FN_RELEASE, TYPE_W'($urandom_range(255)), hdl[IDX_W-1:0], $urandom,
                     TYPE_W'($urandom_range(255)));
         end else if (roll < 95) begin
            if (live_handles.size() != 0)
               hdl = live_handles[$urandom_range(live_handles.size() - 1)];
            else
               hdl = $urandom;
            case ($urandom_range(19))
               10, 11:  hdl[31:24] = hdl[31:24] ^ 8'($urandom_range(255, 1));
               12, 13:  hdl[23:12] = IDX_W'($urandom_range(4095));
               14, 15:  hdl = $urandom;
               16:      hdl = '0;
               17:      hdl = HANDLE_PROCESS;
               18:      hdl = HANDLE_THREAD;
               19:      hdl[IDX_W-1:0] = '0;
               default: ;
            endcase
            case ($urandom_range(3))
               0:       want = hdl[31:24];
               1:       want = any_code_now;
               2:       want = thread_code_now;
               default: want = TYPE_W'($urandom_range(255));
            endcase
            send_req(FN_RESOLVE, TYPE_W'($urandom_range(255)), IDX_W'($urandom_range(4095)),
                     hdl, want);
         end else begin
            send_req(FN_NOP, TYPE_W'($urandom_range(255)), IDX_W'($urandom_range(4095)),
                     $urandom, TYPE_W'($urandom_range(255)));
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_regs(8'h00, 8'h01);

      // Phase one: sender idles now and then, receiver mostly stalls
      req_gap_pct   = 37;
      rsp_stall_pct = 83;

      // directed: null, process and current-thread handles
      send_req(FN_RESOLVE, 8'h00, 12'h000, 32'h0000_0000, 8'h00);
      send_req(FN_RESOLVE, 8'h00, 12'h000, HANDLE_PROCESS, 8'h00);
      send_req(FN_RESOLVE, 8'h00, 12'h000, HANDLE_THREAD, 8'h01);
      send_req(FN_RESOLVE, 8'h00, 12'h000, HANDLE_THREAD, 8'h00);
      // index zero and a slot never allocated
      send_req(FN_RESOLVE, 8'h00, 12'h000, 32'h0100_0000, 8'h00);
      send_req(FN_RESOLVE, 8'h00, 12'h000, 32'h0000_0001, 8'h00);
      // bad releases: index zero and the top index
      send_req(FN_RELEASE, 8'h00, 12'h000, 32'h0, 8'h00);
      send_req(FN_RELEASE, 8'h00, 12'hFFF, 32'h0, 8'h00);
      // allocate with extreme types
      send_req(FN_ALLOC, 8'hFF, 12'h000, 32'h0, 8'h00);
      send_req(FN_ALLOC, 8'h00, 12'h000, 32'h0, 8'h00);
      // resolve: any type, exact type, requested mismatch, stored mismatch; then slot two matching and stored mismatch
      send_req(FN_RESOLVE, 8'h00, 12'h000, 32'hFF00_0001, 8'h00);
      send_req(FN_RESOLVE, 8'h00, 12'h000, 32'hFF00_0001, 8'hFF);
      send_req(FN_RESOLVE, 8'h00, 12'h000, 32'hFF00_0001, 8'h12);
      send_req(FN_RESOLVE, 8'h00, 12'h000, 32'h7F00_0001, 8'h00);
      send_req(FN_RESOLVE, 8'h00, 12'h000, 32'h0000_0002, 8'h00);
      send_req(FN_RESOLVE, 8'h00, 12'h000, 32'hFFFF_F002, 8'h00);
      // unused function code with every field bit set
      send_req(FN_NOP, 8'hFF, 12'hFFF, 32'hFFFF_FFFF, 8'hFF);
      // release, release again, resolve the freed slot, then allocate and resolve a new one
      send_req(FN_RELEASE, 8'h00, 12'h001, 32'h0, 8'h00);
      send_req(FN_RELEASE, 8'h00, 12'h001, 32'h0, 8'h00);
      send_req(FN_RESOLVE, 8'h00, 12'h000, 32'hFF00_0001, 8'h00);
      send_req(FN_ALLOC, 8'hA5, 12'h000, 32'h0, 8'h00);
      send_req(FN_RESOLVE, 8'h00, 12'h000, 32'hA500_0003, 8'hA5);

      random_items(480);
      drain();

      // Phase two: roles swapped, registers at the other extremes
      write_regs(8'hFF, 8'h00);
      req_gap_pct   = 83;
      rsp_stall_pct = 37;
      random_items(500);
      drain();

      // Phase three: no idling on either side
      write_regs(TYPE_W'($urandom_range(254, 1)), 8'hFF);
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      random_items(550);
      drain();

      if (failures == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

@@ typed_handle_table_unit.f @@
+incdir+rtl
rtl/tht_pkg.sv
rtl/typed_handle_table_unit.sv
rtl/tht_checker.sv
test/tht_checker.sv
test/tb.sv
